>>> rtl/tmc_pkg.sv
// ----------------------------------------------------------------------------
// Text-mode console package
// Screen geometry, character codes, command codes and the request and status
// types shared between the console top level and its screen store.
// ----------------------------------------------------------------------------
package tmc_pkg;

    localparam int SCREEN_WIDTH  = 80;
    localparam int SCREEN_HEIGHT = 25;
    localparam int CELL_COUNT    = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int CELL_AW       = $clog2(CELL_COUNT);

    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;
    localparam int CELL_W = 16;

    localparam logic [7:0] CH_NEWLINE = 8'd10;
    localparam logic [7:0] CH_RETURN  = 8'd13;
    localparam logic [7:0] CH_SPACE   = 8'd32;
    localparam logic [7:0] RESET_ATTR = 8'h07;

    typedef enum logic [2:0] {
        CMD_PUT        = 3'd0,
        CMD_SET_CURSOR = 3'd1,
        CMD_CLEAR      = 3'd2,
        CMD_SET_COLOR  = 3'd3,
        CMD_READ       = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        OP_WRITE,
        OP_READ,
        OP_FILL,
        OP_SCROLL
    } t_store_op;

    typedef struct packed {
        logic                valid;
        t_store_op           op;
        logic [CELL_AW-1:0]  addr;
        logic [CELL_W-1:0]   data;
    } t_store_req;

    typedef struct packed {
        logic                ready;
        logic [CELL_W-1:0]   rd_data;
    } t_store_stat;

    function automatic logic [CELL_W-1:0] blank_cell(input logic [7:0] attr);
        blank_cell = {attr, CH_SPACE};
    endfunction

    function automatic logic [CELL_AW-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                     input logic [COL_W-1:0] col);
        cell_addr = CELL_AW'(row) * CELL_AW'(SCREEN_WIDTH) + CELL_AW'(col);
    endfunction

endpackage

>>> rtl/text_mode_console_engine_top.sv
// ----------------------------------------------------------------------------
// Text-mode console engine
// Command-driven 80x25 character screen with cursor, attribute and scrolling.
// ----------------------------------------------------------------------------
// Usage:
// Commands arrive as words on the slave stream and each produces one status
// word on the master stream: cursor row and column, current attribute, the
// cell read by a read command and a scroll flag.
// A simple command (set cursor, set color, carriage return, newline without
// scroll, unused code) goes from execution straight to the result; a read or
// a stored character first waits for the cell store. The next command can be
// accepted in the same cycle as the result is presented.
// A clear walks all 2000 cells at one write per cycle.
// A scroll copies 1920 cells at one read and one write each through the
// single memory port pair and then blanks the bottom row.
// The cell store's index walker performs both.
// After reset the store is cleared to blank grey cells; tready stays low
// meanwhile. One command is in flight at a time.
// The result is held in an output register, so the next command is accepted
// while a result still waits; a stalled receiver blocks the next result and any command after it.
// ----------------------------------------------------------------------------
module text_mode_console_engine_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // Fields from bit 0 up: command(3), character(8), color(8), row(8),
    // column(8), zero fill(5).
    input  logic [39:0] i_s_tdata,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // Fields from bit 0 up: cursor_row_out(5), cursor_column_out(7),
    // attribute_out(8), cell_word(16), scrolled(1), zero fill(3).
    output logic [39:0] o_m_tdata
);
    import tmc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_WAIT_PUT,
        S_WAIT,
        S_DONE
    } t_state;

    t_state             r_state, n_state;
    logic [2:0]         r_cmd, n_cmd;
    logic [7:0]         r_char, n_char;
    logic [7:0]         r_color, n_color;
    logic [7:0]         r_row_in, n_row_in;
    logic [7:0]         r_col_in, n_col_in;
    logic [ROW_W-1:0]   r_cur_row, n_cur_row;
    logic [COL_W-1:0]   r_cur_col, n_cur_col;
    logic [7:0]         r_attr, n_attr;
    logic [CELL_W-1:0]  r_cell, n_cell;
    logic               r_scrolled, n_scrolled;
    logic               r_need_nl, n_need_nl;
    logic               r_out_valid, n_out_valid;
    logic [39:0]        r_out_data, n_out_data;

    t_store_req         store_req;
    t_store_stat        store_stat;
    logic               s_accept;
    logic [7:0]         attr_new;
    logic [ROW_W-1:0]   row_clamp;
    logic [COL_W-1:0]   col_clamp;
    logic               at_bottom;

    tmc_screen_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (store_req),
        .o_stat  (store_stat)
    );

    assign o_s_tready = (r_state == S_IDLE) && store_stat.ready;
    assign s_accept   = i_s_tvalid && o_s_tready;

    assign attr_new  = (r_color != 8'd0) ? r_color : r_attr;
    assign row_clamp = (r_row_in > 8'(SCREEN_HEIGHT - 1)) ? ROW_W'(SCREEN_HEIGHT - 1)
                                                         : ROW_W'(r_row_in);
    assign col_clamp = (r_col_in > 8'(SCREEN_WIDTH - 1)) ? COL_W'(SCREEN_WIDTH - 1)
                                                        : COL_W'(r_col_in);
    assign at_bottom = (r_cur_row == ROW_W'(SCREEN_HEIGHT - 1));

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_char      = r_char;
        n_color     = r_color;
        n_row_in    = r_row_in;
        n_col_in    = r_col_in;
        n_cur_row   = r_cur_row;
        n_cur_col   = r_cur_col;
        n_attr      = r_attr;
        n_cell      = r_cell;
        n_scrolled  = r_scrolled;
        n_need_nl   = r_need_nl;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_data  = r_out_data;
        store_req   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    n_cmd    = i_s_tdata[2:0];
                    n_char   = i_s_tdata[10:3];
                    n_color  = i_s_tdata[18:11];
                    n_row_in = i_s_tdata[26:19];
                    n_col_in = i_s_tdata[34:27];
                    n_state  = S_EXEC;
                end
            end
            S_EXEC: begin
                n_cell     = '0;
                n_scrolled = 1'b0;
                n_state    = S_DONE;
                case (r_cmd)
                    CMD_PUT: begin
                        n_attr = attr_new;
                        if (r_char == CH_NEWLINE) begin
                            n_cur_col = '0;
                            if (at_bottom) begin
                                store_req.valid = 1'b1;
                                store_req.op    = OP_SCROLL;
                                store_req.data  = blank_cell(attr_new);
                                n_scrolled      = 1'b1;
                                n_state         = S_WAIT;
                            end else begin
                                n_cur_row = r_cur_row + 1'b1;
                            end
                        end else if (r_char == CH_RETURN) begin
                            n_cur_col = '0;
                        end else begin
                            store_req.valid = 1'b1;
                            store_req.op    = OP_WRITE;
                            store_req.addr  = cell_addr(r_cur_row, r_cur_col);
                            store_req.data  = {attr_new, r_char};
                            n_need_nl = (r_cur_col == COL_W'(SCREEN_WIDTH - 1));
                            n_state   = S_WAIT_PUT;
                        end
                    end
                    CMD_SET_CURSOR: begin
                        n_cur_row = row_clamp;
                        n_cur_col = col_clamp;
                    end
                    CMD_CLEAR: begin
                        store_req.valid = 1'b1;
                        store_req.op    = OP_FILL;
                        store_req.data  = blank_cell(r_attr);
                        n_cur_row       = '0;
                        n_cur_col       = '0;
                        n_state         = S_WAIT;
                    end
                    CMD_SET_COLOR: begin
                        n_attr = r_color;
                    end
                    CMD_READ: begin
                        store_req.valid = 1'b1;
                        store_req.op    = OP_READ;
                        store_req.addr  = cell_addr(row_clamp, col_clamp);
                        n_state         = S_WAIT;
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_WAIT_PUT: begin
                if (store_stat.ready) begin
                    n_state = S_DONE;
                    if (r_need_nl) begin
                        // Line end: wrap as for a newline, scrolling at the bottom.
                        n_cur_col = '0;
                        if (at_bottom) begin
                            store_req.valid = 1'b1;
                            store_req.op    = OP_SCROLL;
                            store_req.data  = blank_cell(r_attr);
                            n_scrolled      = 1'b1;
                            n_state         = S_WAIT;
                        end else begin
                            n_cur_row = r_cur_row + 1'b1;
                        end
                    end else begin
                        n_cur_col = r_cur_col + 1'b1;
                    end
                end
            end
            S_WAIT: begin
                if (store_stat.ready) begin
                    if (r_cmd == CMD_READ) begin
                        n_cell = store_stat.rd_data;
                    end
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {3'b000, r_scrolled, r_cell, r_attr, r_cur_col, r_cur_row};
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cur_row   <= '0;
            r_cur_col   <= '0;
            r_attr      <= RESET_ATTR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cur_row   <= n_cur_row;
            r_cur_col   <= n_cur_col;
            r_attr      <= n_attr;
            r_out_valid <= n_out_valid;
        end
        r_cmd      <= n_cmd;
        r_char     <= n_char;
        r_color    <= n_color;
        r_row_in   <= n_row_in;
        r_col_in   <= n_col_in;
        r_cell     <= n_cell;
        r_scrolled <= n_scrolled;
        r_need_nl  <= n_need_nl;
        r_out_data <= n_out_data;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

>>> rtl/tmc_screen_store.sv
// ----------------------------------------------------------------------------
// Text-mode console screen store
// Cell memory with a small sequencer for single-cell reads and writes, whole
// screen fills and the one-row scroll. One shared index adder walks the cells.
// ----------------------------------------------------------------------------
module tmc_screen_store (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tmc_pkg::t_store_req  i_req,
    output tmc_pkg::t_store_stat o_stat
);
    import tmc_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACK,
        ST_SCROLL_RD,
        ST_SCROLL_WR,
        ST_FILL
    } t_state;

    logic [CELL_W-1:0]  r_mem [CELL_COUNT];

    t_state             r_state, n_state;
    logic [CELL_AW-1:0] r_idx, n_idx;
    logic [CELL_W-1:0]  r_fill, n_fill;
    logic [CELL_W-1:0]  r_rd_hold, n_rd_hold;
    logic [CELL_W-1:0]  r_rd_data;

    logic [CELL_AW-1:0] addend;
    logic [CELL_AW-1:0] idx_sum;
    logic               we;
    logic [CELL_AW-1:0] wr_addr;
    logic [CELL_W-1:0]  wr_data;
    logic [CELL_AW-1:0] rd_addr;

    // The one adder serves both as the scroll source offset and the step.
    assign addend  = (r_state == ST_SCROLL_RD) ? CELL_AW'(SCREEN_WIDTH) : CELL_AW'(1);
    assign idx_sum = r_idx + addend;

    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_fill    = r_fill;
        n_rd_hold = r_rd_hold;
        we        = 1'b0;
        wr_addr   = r_idx;
        wr_data   = r_fill;
        rd_addr   = r_idx;
        unique case (r_state)
            ST_IDLE: begin
                rd_addr = i_req.addr;
                if (i_req.valid) begin
                    unique case (i_req.op)
                        OP_WRITE: begin
                            we      = 1'b1;
                            wr_addr = i_req.addr;
                            wr_data = i_req.data;
                            n_state = ST_ACK;
                        end
                        OP_READ: begin
                            n_state = ST_ACK;
                        end
                        OP_FILL: begin
                            n_idx   = '0;
                            n_fill  = i_req.data;
                            n_state = ST_FILL;
                        end
                        OP_SCROLL: begin
                            n_idx   = '0;
                            n_fill  = i_req.data;
                            n_state = ST_SCROLL_RD;
                        end
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_ACK: begin
                n_rd_hold = r_rd_data;
                n_state   = ST_IDLE;
            end
            ST_SCROLL_RD: begin
                rd_addr = idx_sum;
                n_state = ST_SCROLL_WR;
            end
            ST_SCROLL_WR: begin
                we      = 1'b1;
                wr_data = r_rd_data;
                n_idx   = idx_sum;
                // After the last copied cell the bottom row is blanked.
                if (r_idx == CELL_AW'(CELL_COUNT - SCREEN_WIDTH - 1)) begin
                    n_state = ST_FILL;
                end else begin
                    n_state = ST_SCROLL_RD;
                end
            end
            ST_FILL: begin
                we = 1'b1;
                if (r_idx == CELL_AW'(CELL_COUNT - 1)) begin
                    n_state = ST_IDLE;
                end else begin
                    n_idx = idx_sum;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            // Reset starts a clearing pass with the default blank cell.
            r_state   <= ST_FILL;
            r_idx     <= '0;
            r_fill    <= blank_cell(RESET_ATTR);
            r_rd_hold <= '0;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_fill    <= n_fill;
            r_rd_hold <= n_rd_hold;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    assign o_stat.ready   = (r_state == ST_IDLE);
    assign o_stat.rd_data = r_rd_hold;

endmodule

>>> rtl/tmc_checker.sv
// ----------------------------------------------------------------------------
// Text-mode console port checker
// Watches the stream ports of the console top level for ordering and range
// properties of its results.
// ----------------------------------------------------------------------------
module tmc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [39:0] o_m_tdata
);
    import tmc_pkg::*;

    // The store clearing pass keeps the input closed right after reset.
    a_closed_after_reset: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !o_s_tready)
        else $error("input ready right after reset");

    // One command at a time: ready drops after every accepted word.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("second word accepted while a command is in flight");

    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("stalled result changed or dropped");

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> ((o_m_tdata[4:0] <= ROW_W'(SCREEN_HEIGHT - 1)) &&
                        (o_m_tdata[11:5] <= COL_W'(SCREEN_WIDTH - 1))))
        else $error("cursor reported outside the screen");

    // A scroll always leaves the cursor at the start of the bottom row.
    a_scroll_cursor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[36]) |->
            ((o_m_tdata[4:0] == ROW_W'(SCREEN_HEIGHT - 1)) && (o_m_tdata[11:5] == '0)))
        else $error("scroll reported with cursor off the bottom row start");

endmodule

bind text_mode_console_engine_top tmc_checker u_tmc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
